/* hdl/bsa_pkg.sv */
// Shared constants and types for the bitmap slot allocator.
// Used by bsa_scan and bitmap_slot_allocator_with_cache; no dependencies.
package bsa_pkg;

    localparam int MASK_WORDS  = 16;
    localparam int WORD_BITS   = 64;
    localparam int CACHE_DEPTH = 16;
    localparam int CHUNK_BITS  = 16;

    localparam int POOL_SLOTS  = MASK_WORDS * WORD_BITS;
    localparam int CHUNKS      = WORD_BITS / CHUNK_BITS;

    localparam int SLOT_W      = 10;
    localparam int COUNT_W     = 11;
    localparam int STATUS_W    = 2;
    localparam int LIMIT_W     = 5;
    localparam int WORD_IDX_W  = $clog2(MASK_WORDS);
    localparam int BIT_IDX_W   = $clog2(WORD_BITS);
    localparam int CHUNK_IDX_W = $clog2(CHUNKS);
    localparam int CHUNK_BIT_W = $clog2(CHUNK_BITS);
    localparam int STACK_IDX_W = $clog2(CACHE_DEPTH);
    localparam int DEPTH_W     = $clog2(CACHE_DEPTH + 1);

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_FREE = 2'd2;

    typedef logic [WORD_BITS-1:0] word_t;

    typedef struct packed {
        logic  start;
        word_t word;
    } scan_req_t;

    typedef struct packed {
        logic                 busy;
        logic                 done;
        logic [BIT_IDX_W-1:0] bit_idx;
    } scan_stat_t;

endpackage

/* hdl/bsa_scan.sv */
// Lowest-clear-bit search over one bitmap word, one chunk per cycle.
// Depends on bsa_pkg.
module bsa_scan
    import bsa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  scan_req_t  req,
    output scan_stat_t stat
);

    function automatic logic [CHUNK_BIT_W-1:0] lowest_clear(
        input logic [CHUNK_BITS-1:0] chunk
    );
        logic [CHUNK_BIT_W-1:0] pos;
        pos = '0;
        for (int i = CHUNK_BITS - 1; i >= 0; i--)
        begin
            if (!chunk[i])
            begin
                pos = CHUNK_BIT_W'(i);
            end
        end
        return pos;
    endfunction

    word_t                  word_reg;
    logic [CHUNK_IDX_W-1:0] chunk_reg;
    logic                   busy_reg;
    logic                   done_reg;
    logic [BIT_IDX_W-1:0]   bit_idx_reg;
    logic [CHUNK_BITS-1:0]  chunk;

    assign chunk = word_reg[int'(chunk_reg) * CHUNK_BITS +: CHUNK_BITS];

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            word_reg <= req.word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chunk_reg   <= '0;
            busy_reg    <= 1'b0;
            done_reg    <= 1'b0;
            bit_idx_reg <= '0;
        end
        else
        begin
            done_reg <= busy_reg && !req.start && !(&chunk);
            if (req.start)
            begin
                chunk_reg <= '0;
                busy_reg  <= 1'b1;
            end
            else if (busy_reg)
            begin
                if (!(&chunk))
                begin
                    bit_idx_reg <= {chunk_reg, lowest_clear(chunk)};
                    busy_reg    <= 1'b0;
                end
                else
                begin
                    chunk_reg <= chunk_reg + 1'b1;
                end
            end
        end
    end

    assign stat.busy    = busy_reg;
    assign stat.done    = done_reg;
    assign stat.bit_idx = bit_idx_reg;

endmodule

/* hdl/bitmap_slot_allocator_with_cache.sv */
// Top level of the bitmap slot allocator with a reuse stack.
// Depends on bsa_pkg and bsa_scan.
//
// Input channel (in_valid/in_ready): one word per request, kind 0 allocates
// a slot, kind 1 frees slot_in. Output channel (out_valid/out_ready): one
// word per request with slot_out, status, from_cache and free_slots.
// cfg_we/cfg_wdata write cache_limit; write only while the block is idle.
// One request is in flight at a time; in_ready is high only when idle.
// Paths from accept to out_valid: an allocate served by the reuse stack or an
// allocate on a full pool goes S_IDLE, S_HOLD; a free goes S_IDLE, S_FREE,
// S_HOLD; an allocate from the bitmap goes S_IDLE, S_SCAN, S_HOLD and waits
// in S_SCAN for the chunk scanner, which tests one 16-bit chunk of the
// selected word per cycle (up to 4). in_ready returns together with out_valid.
// A new request is accepted while a result still waits in the output
// register; a finished result then holds until the register frees up.
// Reset: every slot free, free count 1024, stack empty, cache_limit 16,
// out_valid low.
module bitmap_slot_allocator_with_cache
    import bsa_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                kind,
    input  logic [SLOT_W-1:0]   slot_in,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [SLOT_W-1:0]   slot_out,
    output logic [STATUS_W-1:0] status,
    output logic                from_cache,
    output logic [COUNT_W-1:0]  free_slots,
    input  logic                cfg_we,
    input  logic [LIMIT_W-1:0]  cfg_wdata
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_FREE,
        S_SCAN,
        S_HOLD
    } state_t;

    state_t                  state_reg;
    word_t                   bitmap_reg [MASK_WORDS];
    logic [MASK_WORDS-1:0]   full_reg;
    logic [COUNT_W-1:0]      free_total_reg;
    logic [SLOT_W-1:0]       stack_reg [CACHE_DEPTH];
    logic [DEPTH_W-1:0]      depth_reg;
    logic [LIMIT_W-1:0]      cache_limit_reg;

    logic [SLOT_W-1:0]       slot_reg;
    logic [WORD_IDX_W-1:0]   word_idx_reg;
    logic [SLOT_W-1:0]       res_slot_reg;
    logic [STATUS_W-1:0]     res_status_reg;
    logic                    res_cache_reg;

    logic                    out_valid_reg;
    logic [SLOT_W-1:0]       out_slot_reg;
    logic [STATUS_W-1:0]     out_status_reg;
    logic                    out_cache_reg;
    logic [COUNT_W-1:0]      out_free_reg;

    logic                    accept;
    logic                    any_free;
    logic [WORD_IDX_W-1:0]   free_word;
    logic [LIMIT_W-1:0]      limit;
    logic [WORD_IDX_W-1:0]   slot_word;
    logic [BIT_IDX_W-1:0]    slot_bit;
    logic                    push;
    logic                    out_free;
    word_t                   grant_word;
    scan_req_t               scan_req;
    scan_stat_t              scan_stat;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign any_free  = !(&full_reg);
    assign limit     = (cache_limit_reg > LIMIT_W'(CACHE_DEPTH))
                       ? LIMIT_W'(CACHE_DEPTH) : cache_limit_reg;
    assign slot_word = slot_reg[SLOT_W-1 -: WORD_IDX_W];
    assign slot_bit  = slot_reg[BIT_IDX_W-1:0];
    assign out_free  = !out_valid_reg || out_ready;
    assign grant_word = bitmap_reg[word_idx_reg]
                        | (word_t'(1) << scan_stat.bit_idx);

    always_comb
    begin
        free_word = '0;
        for (int w = MASK_WORDS - 1; w >= 0; w--)
        begin
            if (!full_reg[w])
            begin
                free_word = WORD_IDX_W'(w);
            end
        end
    end

    assign scan_req.start = accept && (kind == KIND_ALLOC) && (depth_reg == '0)
                            && any_free;
    assign scan_req.word  = bitmap_reg[free_word];

    bsa_scan u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (scan_req),
        .stat  (scan_stat)
    );

    assign push = (state_reg == S_FREE) && bitmap_reg[slot_word][slot_bit]
                  && (LIMIT_W'(depth_reg) < limit);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            stack_reg[depth_reg[STACK_IDX_W-1:0]] <= slot_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            for (int w = 0; w < MASK_WORDS; w++)
            begin
                bitmap_reg[w] <= '0;
            end
            full_reg        <= '0;
            free_total_reg  <= COUNT_W'(POOL_SLOTS);
            depth_reg       <= '0;
            cache_limit_reg <= LIMIT_W'(CACHE_DEPTH);
            slot_reg        <= '0;
            word_idx_reg    <= '0;
            res_slot_reg    <= '0;
            res_status_reg  <= ST_OK;
            res_cache_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
            out_slot_reg    <= '0;
            out_status_reg  <= ST_OK;
            out_cache_reg   <= 1'b0;
            out_free_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                cache_limit_reg <= cfg_wdata;
            end
            if (out_valid_reg && out_ready && (state_reg != S_HOLD))
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        slot_reg     <= slot_in;
                        word_idx_reg <= free_word;
                        if (kind == KIND_FREE)
                        begin
                            state_reg <= S_FREE;
                        end
                        else if (depth_reg != '0)
                        begin
                            depth_reg      <= depth_reg - 1'b1;
                            res_slot_reg   <= stack_reg[STACK_IDX_W'(depth_reg - 1'b1)];
                            res_status_reg <= ST_OK;
                            res_cache_reg  <= 1'b1;
                            state_reg      <= S_HOLD;
                        end
                        else if (!any_free)
                        begin
                            res_slot_reg   <= '0;
                            res_status_reg <= ST_FULL;
                            res_cache_reg  <= 1'b0;
                            state_reg      <= S_HOLD;
                        end
                        else
                        begin
                            state_reg <= S_SCAN;
                        end
                    end
                end

                S_FREE:
                begin
                    res_slot_reg <= slot_reg;
                    if (!bitmap_reg[slot_word][slot_bit])
                    begin
                        res_status_reg <= ST_BAD_FREE;
                        res_cache_reg  <= 1'b0;
                    end
                    else if (push)
                    begin
                        depth_reg      <= depth_reg + 1'b1;
                        res_status_reg <= ST_OK;
                        res_cache_reg  <= 1'b1;
                    end
                    else
                    begin
                        bitmap_reg[slot_word][slot_bit] <= 1'b0;
                        full_reg[slot_word]             <= 1'b0;
                        free_total_reg                  <= free_total_reg + 1'b1;
                        res_status_reg                  <= ST_OK;
                        res_cache_reg                   <= 1'b0;
                    end
                    state_reg <= S_HOLD;
                end

                S_SCAN:
                begin
                    if (scan_stat.done)
                    begin
                        bitmap_reg[word_idx_reg] <= grant_word;
                        full_reg[word_idx_reg]   <= &grant_word;
                        free_total_reg           <= free_total_reg - 1'b1;
                        res_slot_reg             <= {word_idx_reg, scan_stat.bit_idx};
                        res_status_reg           <= ST_OK;
                        res_cache_reg            <= 1'b0;
                        state_reg                <= S_HOLD;
                    end
                end

                S_HOLD:
                begin
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_slot_reg   <= res_slot_reg;
                        out_status_reg <= res_status_reg;
                        out_cache_reg  <= res_cache_reg;
                        out_free_reg   <= free_total_reg;
                        state_reg      <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign slot_out   = out_slot_reg;
    assign status     = out_status_reg;
    assign from_cache = out_cache_reg;
    assign free_slots = out_free_reg;

    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= DEPTH_W'(CACHE_DEPTH))
        else $error("reuse stack depth beyond its size");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        free_total_reg <= COUNT_W'(POOL_SLOTS))
        else $error("free count beyond pool size");

    a_scan_owner: assert property (@(posedge clk) disable iff (!rst_n)
        scan_stat.done |-> state_reg == S_SCAN)
        else $error("scanner finished outside a bitmap allocate");

    a_scan_start: assert property (@(posedge clk) disable iff (!rst_n)
        scan_req.start |=> state_reg == S_SCAN && scan_stat.busy)
        else $error("bitmap allocate did not start the scanner");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !in_ready)
        else $error("second request taken while one is in flight");

endmodule

/* tb/sv/tb.sv */
// Self-checking testbench for bitmap_slot_allocator_with_cache: directed rows,
// then random allocate/free traffic checked against an in-bench allocator model.
// Depends on bsa_pkg and the RTL top level; needs no files or arguments.
module tb;
    import bsa_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int LONG_HOLD   = 80;

    typedef struct packed {
        logic [SLOT_W-1:0]   slot;
        logic [STATUS_W-1:0] st;
        logic                cached;
        logic [COUNT_W-1:0]  count;
    } grant_t;

    typedef enum logic {ROW_WORD, ROW_LIMIT} row_op_t;

    typedef struct {
        row_op_t           op;
        logic              k;
        logic [SLOT_W-1:0] s;
        logic [LIMIT_W-1:0] lim;
        bit                typed;
        grant_t            want;
    } dir_row_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic                kind = KIND_ALLOC;
    logic [SLOT_W-1:0]   slot_in = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [SLOT_W-1:0]   slot_out;
    logic [STATUS_W-1:0] status;
    logic                from_cache;
    logic [COUNT_W-1:0]  free_slots;
    logic                cfg_we = 1'b0;
    logic [LIMIT_W-1:0]  cfg_wdata = '0;

    logic [WORD_BITS-1:0] used_map [MASK_WORDS];
    logic [SLOT_W-1:0]    stack_slots [CACHE_DEPTH];
    int unsigned          stack_top;
    int unsigned          pool_free;
    int unsigned          limit_reg;

    grant_t   expected_grants [$];
    dir_row_t dir_rows [$];
    grant_t   head_grant;
    int       errors = 0;
    int       cycle_count = 0;
    bit       long_hold_go = 1'b0;

    bitmap_slot_allocator_with_cache u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .kind       (kind),
        .slot_in    (slot_in),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .slot_out   (slot_out),
        .status     (status),
        .from_cache (from_cache),
        .free_slots (free_slots),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("bitmap_slot_allocator_with_cache verification failed");
            $finish;
        end
    end

    task automatic flag_mismatch(input string msg);
        errors++;
        if (errors <= 40)
            $display("MISMATCH cycle %0d: %s", cycle_count, msg);
    endtask

    task automatic predict_grant(input logic k, input logic [SLOT_W-1:0] s,
                                 output grant_t r);
        int unsigned eff;
        int unsigned w;
        int unsigned b;
        bit          found;
        eff = (limit_reg > CACHE_DEPTH) ? CACHE_DEPTH : limit_reg;
        r = '0;
        found = 1'b0;
        if (k == KIND_ALLOC)
        begin
            if (stack_top > 0)
            begin
                stack_top--;
                r.slot = stack_slots[stack_top];
                r.cached = 1'b1;
            end
            else
            begin
                r.st = ST_FULL;
                for (w = 0; w < MASK_WORDS; w++)
                    for (b = 0; b < WORD_BITS; b++)
                        if (!found && !used_map[w][b])
                        begin
                            found = 1'b1;
                            used_map[w][b] = 1'b1;
                            pool_free--;
                            r.slot = SLOT_W'(w * WORD_BITS + b);
                            r.st = ST_OK;
                        end
            end
        end
        else
        begin
            w = s / WORD_BITS;
            b = s % WORD_BITS;
            r.slot = s;
            if (!used_map[w][b])
                r.st = ST_BAD_FREE;
            else if (stack_top < eff)
            begin
                stack_slots[stack_top] = s;
                stack_top++;
                r.cached = 1'b1;
            end
            else
            begin
                used_map[w][b] = 1'b0;
                pool_free++;
            end
        end
        r.count = COUNT_W'(pool_free);
    endtask

    function automatic logic [SLOT_W-1:0] pick_held();
        int unsigned start;
        int unsigned c;
        int unsigned i;
        start = $urandom_range(0, POOL_SLOTS - 1);
        for (i = 0; i < POOL_SLOTS; i++)
        begin
            c = (start + i) % POOL_SLOTS;
            if (used_map[c / WORD_BITS][c % WORD_BITS])
                return SLOT_W'(c);
        end
        return SLOT_W'(start);
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 45);
    endfunction

    task automatic send_word(input logic k, input logic [SLOT_W-1:0] s,
                             input bit typed, input grant_t want);
        grant_t r;
        in_valid <= 1'b1;
        kind <= k;
        slot_in <= s;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_grant(k, s, r);
        expected_grants.push_back(typed ? want : r);
    endtask

    task automatic idle_gap(input int n);
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (expected_grants.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    task automatic set_limit(input logic [LIMIT_W-1:0] v);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        limit_reg = v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic row_typed(input logic k, input int s, input int slot,
                             input logic [STATUS_W-1:0] st, input logic fc,
                             input int cnt);
        dir_row_t r;
        r.op = ROW_WORD;
        r.k = k;
        r.s = SLOT_W'(s);
        r.lim = '0;
        r.typed = 1'b1;
        r.want.slot = SLOT_W'(slot);
        r.want.st = st;
        r.want.cached = fc;
        r.want.count = COUNT_W'(cnt);
        dir_rows.push_back(r);
    endtask

    task automatic row_word(input logic k, input int s);
        dir_row_t r;
        r.op = ROW_WORD;
        r.k = k;
        r.s = SLOT_W'(s);
        r.lim = '0;
        r.typed = 1'b0;
        r.want = '0;
        dir_rows.push_back(r);
    endtask

    task automatic row_limit(input int v);
        dir_row_t r;
        r.op = ROW_LIMIT;
        r.k = KIND_ALLOC;
        r.s = '0;
        r.lim = LIMIT_W'(v);
        r.typed = 1'b0;
        r.want = '0;
        dir_rows.push_back(r);
    endtask

    task automatic run_traffic(input int count, input int alloc_pct,
                               input bit stop_full, input int burst);
        int            n;
        logic          k;
        logic [SLOT_W-1:0] s;
        n = 0;
        while (n < count && !(stop_full && pool_free == 0))
        begin
            if ($urandom_range(0, 99) < alloc_pct)
            begin
                k = KIND_ALLOC;
                s = SLOT_W'($urandom_range(0, POOL_SLOTS - 1));
            end
            else
            begin
                k = KIND_FREE;
                if ($urandom_range(0, 99) < 85)
                    s = pick_held();
                else
                    s = SLOT_W'($urandom_range(0, POOL_SLOTS - 1));
            end
            send_word(k, s, 1'b0, '0);
            if (n >= burst && (n % 64) >= 16)
                idle_gap(pick_gap());
            n++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_grants.size() == 0)
                flag_mismatch($sformatf("result with nothing pending, slot_out %0d",
                                        slot_out));
            else
            begin
                head_grant = expected_grants.pop_front();
                if (slot_out !== head_grant.slot)
                    flag_mismatch($sformatf("slot_out %0d, want %0d",
                                            slot_out, head_grant.slot));
                if (status !== head_grant.st)
                    flag_mismatch($sformatf("status %0d, want %0d",
                                            status, head_grant.st));
                if (from_cache !== head_grant.cached)
                    flag_mismatch($sformatf("from_cache %0d, want %0d",
                                            from_cache, head_grant.cached));
                if (free_slots !== head_grant.count)
                    flag_mismatch($sformatf("free_slots %0d, want %0d",
                                            free_slots, head_grant.count));
            end
        end
    end

    initial
    begin : rx_side
        int  n;
        bit  long_done;
        long_done = 1'b0;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (long_hold_go && !long_done)
            begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                long_done = 1'b1;
            end
            else
            begin
                n = pick_gap();
                if (n > 0)
                begin
                    out_ready <= 1'b0;
                    repeat (n) @(posedge clk);
                end
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge clk);
            end
        end
    end

    initial
    begin : tx_side
        int i;
        for (i = 0; i < MASK_WORDS; i++)
            used_map[i] = '0;
        for (i = 0; i < CACHE_DEPTH; i++)
            stack_slots[i] = '0;
        stack_top = 0;
        pool_free = POOL_SLOTS;
        limit_reg = 16;

        row_typed(KIND_ALLOC, 0,    0,    ST_OK,       1'b0, 1023);
        row_typed(KIND_ALLOC, 0,    1,    ST_OK,       1'b0, 1022);
        row_typed(KIND_FREE,  5,    5,    ST_BAD_FREE, 1'b0, 1022);
        row_typed(KIND_FREE,  1023, 1023, ST_BAD_FREE, 1'b0, 1022);
        row_typed(KIND_FREE,  0,    0,    ST_OK,       1'b1, 1022);
        row_typed(KIND_FREE,  0,    0,    ST_OK,       1'b1, 1022);
        row_typed(KIND_ALLOC, 1023, 0,    ST_OK,       1'b1, 1022);
        row_typed(KIND_ALLOC, 0,    0,    ST_OK,       1'b1, 1022);
        row_typed(KIND_ALLOC, 0,    2,    ST_OK,       1'b0, 1021);
        row_limit(0);
        row_typed(KIND_FREE,  1,    1,    ST_OK,       1'b0, 1022);
        row_typed(KIND_ALLOC, 0,    1,    ST_OK,       1'b0, 1021);
        row_typed(KIND_FREE,  2,    2,    ST_OK,       1'b0, 1022);
        row_limit(31);
        row_typed(KIND_FREE,  1,    1,    ST_OK,       1'b1, 1022);
        row_typed(KIND_FREE,  0,    0,    ST_OK,       1'b1, 1022);
        row_limit(1);
        row_typed(KIND_FREE,  1,    1,    ST_OK,       1'b0, 1023);
        row_word(KIND_ALLOC, 0);
        row_word(KIND_ALLOC, 0);
        row_word(KIND_ALLOC, 0);
        row_word(KIND_FREE, 512);
        row_word(KIND_FREE, 0);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].op == ROW_LIMIT)
                set_limit(dir_rows[i].lim);
            else
            begin
                send_word(dir_rows[i].k, dir_rows[i].s, dir_rows[i].typed,
                          dir_rows[i].want);
                idle_gap(pick_gap());
            end
        end

        set_limit(16);
        run_traffic(200, 60, 1'b0, 0);

        // hold the receiver off while a burst keeps the input busy
        set_limit(3);
        long_hold_go <= 1'b1;
        run_traffic(150, 50, 1'b0, 48);

        // push allocates deep into the bitmap with the stack off
        set_limit(0);
        run_traffic(150, 85, 1'b1, 0);

        set_limit(16);
        run_traffic(100, 40, 1'b0, 0);

        set_limit(LIMIT_W'($urandom_range(17, 31)));
        run_traffic(70, 45, 1'b0, 0);

        set_limit(LIMIT_W'($urandom_range(1, 15)));
        run_traffic(70, 50, 1'b0, 0);

        drain();
        if (errors == 0)
            $display("bitmap_slot_allocator_with_cache verification clean");
        else
            $display("bitmap_slot_allocator_with_cache verification failed");
        $finish;
    end

endmodule

/* bitmap_slot_allocator_with_cache.f */
hdl/bsa_pkg.sv
hdl/bsa_scan.sv
hdl/bitmap_slot_allocator_with_cache.sv
tb/sv/tb.sv
